// ----- src/mcr_pkg.sv -----
// Shared types and constants for the midpoint circle rasterizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mcr_pkg;

	// Default coordinate width of center and radius storage.
	localparam int COORD_BITS_DEF = 10;

	// Fixed widths of the request and result fields.
	localparam int IN_W  = 10;
	localparam int PIX_W = 12;

	// Points per symmetric group and the width of a point index.
	localparam int POINTS_PER_GROUP = 8;
	localparam int IDX_W            = $clog2(POINTS_PER_GROUP);

	// Depth of the group queue between front and back; a power of two.
	localparam int GQ_DEPTH = 2;

	// Request kinds.
	typedef enum logic [0:0] {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_kind_t;

	// One request item.
	typedef struct packed {
		req_kind_t         req_type;
		logic [IN_W-1:0]   center_x;
		logic [IN_W-1:0]   center_y;
		logic [IN_W-1:0]   radius;
	} req_t;

	// One result item.
	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
		logic                    last_of_group;
		logic                    circle_done;
	} res_t;

	// One point group handed from front to back. Coordinates are kept modulo
	// the pixel width, which is all the output sums need.
	typedef struct packed {
		logic [PIX_W-1:0] cx;
		logic [PIX_W-1:0] cy;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		logic             done;
	} grp_t;

endpackage

`default_nettype wire

// ----- src/mcr_front.sv -----
// Front end of the rasterizer: accepts requests, keeps the circle state and
// queues one point group per start or productive step. Depends on mcr_pkg.
`default_nettype none

module mcr_front #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire mcr_pkg::req_t req,
	output logic              full,
	output logic              gq_push,
	output mcr_pkg::grp_t     gq_data,
	input  wire logic         gq_full
);

	localparam int XY_W  = COORD_BITS + 1;
	localparam int DEC_W = COORD_BITS + 3;

	logic [COORD_BITS-1:0] cx_q, cy_q, cx_n, cy_n, r_in;
	logic [XY_W-1:0]       x_q, y_q, x_n, y_n, x_inc;
	logic [DEC_W-1:0]      dec_q, dec_n;
	logic                  accept;
	logic                  emit;

	// A request is taken whenever the group queue has room.
	assign full   = gq_full;
	assign accept = push && !gq_full;
	assign r_in   = COORD_BITS'(req.radius);
	assign x_inc  = x_q + XY_W'(1);

	// Classify the request and work out the next circle state.
	always_comb begin
		cx_n  = cx_q;
		cy_n  = cy_q;
		x_n   = x_q;
		y_n   = y_q;
		dec_n = dec_q;
		emit  = 1'b0;
		case (req.req_type)
			mcr_pkg::REQ_START: begin
				cx_n  = COORD_BITS'(req.center_x);
				cy_n  = COORD_BITS'(req.center_y);
				x_n   = '0;
				y_n   = XY_W'(r_in);
				dec_n = DEC_W'(1) - DEC_W'(r_in);
				emit  = 1'b1;
			end
			mcr_pkg::REQ_STEP: begin
				if (x_q < y_q) begin
					x_n  = x_inc;
					emit = 1'b1;
					if (dec_q[DEC_W-1]) begin
						dec_n = dec_q + (DEC_W'(x_inc) << 1) + DEC_W'(1);
					end else begin
						y_n   = y_q - XY_W'(1);
						dec_n = dec_q + ((DEC_W'(x_inc) - DEC_W'(y_n)) << 1) + DEC_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The queued group carries the updated position.
	assign gq_push      = accept && emit;
	assign gq_data.cx   = mcr_pkg::PIX_W'(cx_n);
	assign gq_data.cy   = mcr_pkg::PIX_W'(cy_n);
	assign gq_data.x    = mcr_pkg::PIX_W'(x_n);
	assign gq_data.y    = mcr_pkg::PIX_W'(y_n);
	assign gq_data.done = !(x_n < y_n);

	// Circle state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			x_q   <= '0;
			y_q   <= '0;
			dec_q <= '0;
		end else if (accept) begin
			cx_q  <= cx_n;
			cy_q  <= cy_n;
			x_q   <= x_n;
			y_q   <= y_n;
			dec_q <= dec_n;
		end
	end

endmodule

`default_nettype wire

// ----- src/mcr_group_fifo.sv -----
// Short queue of point groups between the front and back of the rasterizer.
// Depends on mcr_pkg for the group type and depth.
`default_nettype none

module mcr_group_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire mcr_pkg::grp_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output mcr_pkg::grp_t      rd_data,
	output logic               empty
);

	localparam int DEPTH = mcr_pkg::GQ_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	mcr_pkg::grp_t  entry_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [AW:0]    count_q;

	assign full    = count_q == (AW+1)'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count; pointers wrap since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/mcr_back.sv -----
// Back end of the rasterizer (needs mcr_pkg): expands each queued group into
// its eight symmetric points, one per cycle unless the output register stalls.
`default_nettype none

module mcr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mcr_pkg::grp_t gq_data,
	input  wire logic          gq_empty,
	output logic               gq_pop,
	output mcr_pkg::res_t      res,
	output logic               empty,
	input  wire logic          pop
);

	localparam int IW = mcr_pkg::IDX_W;
	localparam int PW = mcr_pkg::PIX_W;

	mcr_pkg::grp_t grp_q;
	logic          grp_valid_q;
	logic [IW-1:0] idx_q;
	mcr_pkg::res_t out_q;
	logic          out_valid_q;
	logic          advance;
	logic          last_pt;
	logic [PW-1:0] term_a, term_b, px, py;

	// A point moves into the output register when it is free or being taken.
	assign advance = grp_valid_q && (!out_valid_q || pop);
	assign last_pt = idx_q == IW'(mcr_pkg::POINTS_PER_GROUP - 1);
	assign gq_pop  = !gq_empty && (!grp_valid_q || (advance && last_pt));

	// Point order: bit 0 mirrors x, bit 1 mirrors y, bit 2 swaps the octant.
	always_comb begin
		term_a = idx_q[2] ? grp_q.y : grp_q.x;
		term_b = idx_q[2] ? grp_q.x : grp_q.y;
		px     = idx_q[0] ? grp_q.cx - term_a : grp_q.cx + term_a;
		py     = idx_q[1] ? grp_q.cy - term_b : grp_q.cy + term_b;
	end

	// Group and output payload registers.
	always_ff @(posedge clk) begin
		if (gq_pop) begin
			grp_q <= gq_data;
		end
		if (advance) begin
			out_q.pixel_x       <= px;
			out_q.pixel_y       <= py;
			out_q.last_of_group <= last_pt;
			out_q.circle_done   <= grp_q.done;
		end
	end

	// Group sequencing and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (gq_pop) begin
				grp_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance) begin
				idx_q <= idx_q + IW'(1);
				if (last_pt) begin
					grp_valid_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res   = out_q;
	assign empty = !out_valid_q;

endmodule

`default_nettype wire

// ----- src/midpoint_circle_rasterizer_top.sv -----
// Midpoint circle rasterizer, top level.
// Request side: a request is transferred when push is high and full is low.
// A start request loads center and radius and yields the eight symmetric
// points of (0, radius); a step request advances x by one and yields the
// eight points of the new position, or nothing once x is no longer below y.
// Result side: while empty is low, the oldest point is on res; it is
// transferred when pop is high. last_of_group marks the eighth point of a
// group, circle_done marks every point of the circle's final group.
// A request's group is written to the group queue, then moved into the group
// register, and its first point into the output register. The point expander
// emits one point per cycle while the receiver keeps taking them.
// A two-entry group queue lets requests be taken while points drain.
// When the receiver stalls, the points hold, the group queue fills and full
// rises. Reset clears the circle state to zero, so a step before any start
// yields nothing; reset also empties the queue and the output register.
// Depends on mcr_pkg, mcr_front, mcr_group_fifo and mcr_back.
`default_nettype none

module midpoint_circle_rasterizer_top #(
	parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mcr_pkg::req_t req,
	output logic               full,
	output logic               empty,
	input  wire logic          pop,
	output mcr_pkg::res_t      res
);

	logic          gq_push, gq_full, gq_pop, gq_empty;
	mcr_pkg::grp_t gq_wr_data, gq_rd_data;

	mcr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.req     (req),
		.full    (full),
		.gq_push (gq_push),
		.gq_data (gq_wr_data),
		.gq_full (gq_full)
	);

	mcr_group_fifo u_gq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (gq_push),
		.wr_data (gq_wr_data),
		.full    (gq_full),
		.rd_en   (gq_pop),
		.rd_data (gq_rd_data),
		.empty   (gq_empty)
	);

	mcr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.gq_data  (gq_rd_data),
		.gq_empty (gq_empty),
		.gq_pop   (gq_pop),
		.res      (res),
		.empty    (empty),
		.pop      (pop)
	);

`ifndef SYNTHESIS
	// The group queue is never written when full nor read when empty.
	a_gq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(gq_push && gq_full))
		else $error("group queue written while full");

	a_gq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(gq_pop && gq_empty))
		else $error("group queue read while empty");

	// Within a group the next point follows at once and keeps the done flag.
	a_group_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !res.last_of_group) |=>
		(!empty && res.circle_done == $past(res.circle_done)))
		else $error("point group broken up");
`endif

endmodule

`default_nettype wire

// ----- verif/midpoint_circle_rasterizer_top_tb.sv -----
// Self-checking testbench for the midpoint circle rasterizer top level.
// Needs mcr_pkg and midpoint_circle_rasterizer_top; a scoreboard class predicts
// every plotted point and checks the points that come out of the block.

module midpoint_circle_rasterizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 32;
	localparam int TARGET_ITEMS = 460;
	localparam int MAX_PRINTED  = 20;

	// Predicts the point stream of the rasterizer and checks what comes out.
	class circle_scoreboard;
		mcr_pkg::res_t expected_points[$];
		logic [10:0]   pos_x;
		logic [10:0]   pos_y;
		logic [12:0]   dec_term;
		logic [9:0]    org_x;
		logic [9:0]    org_y;
		int            mismatches;
		int            groups_predicted;
		int            points_checked;
		int            starts_seen;

		function new();
			pos_x = '0;
			pos_y = '0;
			dec_term = '0;
			org_x = '0;
			org_y = '0;
			mismatches = 0;
			groups_predicted = 0;
			points_checked = 0;
			starts_seen = 0;
		endfunction

		function void add_point(input logic [11:0] px, input logic [11:0] py,
				input logic last, input logic done);
			mcr_pkg::res_t p;
			p.pixel_x = px;
			p.pixel_y = py;
			p.last_of_group = last;
			p.circle_done = done;
			expected_points.push_back(p);
		endfunction

		// Eight symmetric points of the current position, in octant order.
		function void predict_group();
			logic [11:0] cx;
			logic [11:0] cy;
			logic [11:0] x;
			logic [11:0] y;
			logic        done;
			cx = {2'b00, org_x};
			cy = {2'b00, org_y};
			x = {1'b0, pos_x};
			y = {1'b0, pos_y};
			done = !(pos_x < pos_y);
			add_point(cx + x, cy + y, 1'b0, done);
			add_point(cx - x, cy + y, 1'b0, done);
			add_point(cx + x, cy - y, 1'b0, done);
			add_point(cx - x, cy - y, 1'b0, done);
			add_point(cx + y, cy + x, 1'b0, done);
			add_point(cx - y, cy + x, 1'b0, done);
			add_point(cx + y, cy - x, 1'b0, done);
			add_point(cx - y, cy - x, 1'b1, done);
			groups_predicted++;
		endfunction

		// Called for every request transfer.
		function void note_request(input mcr_pkg::req_t r);
			logic [12:0] diff;
			if (r.req_type == mcr_pkg::REQ_START) begin
				org_x = r.center_x;
				org_y = r.center_y;
				pos_x = 11'd0;
				pos_y = {1'b0, r.radius};
				dec_term = 13'd1 - {3'b000, r.radius};
				starts_seen++;
				predict_group();
			end else if (pos_x < pos_y) begin
				pos_x = pos_x + 11'd1;
				if (dec_term[12]) begin
					// Midpoint inside the circle: y stays.
					dec_term = dec_term + {1'b0, pos_x, 1'b0} + 13'd1;
				end else begin
					pos_y = pos_y - 11'd1;
					diff = {2'b00, pos_x} - {2'b00, pos_y};
					dec_term = dec_term + {diff[11:0], 1'b0} + 13'd1;
				end
				predict_group();
			end
		endfunction

		task report_mismatch(input string msg);
			if (mismatches < MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		// Called for every result transfer.
		task check_result(input mcr_pkg::res_t got);
			mcr_pkg::res_t want;
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point x=%h y=%h last=%b done=%b",
					got.pixel_x, got.pixel_y, got.last_of_group, got.circle_done));
			end else begin
				want = expected_points.pop_front();
				if (got.pixel_x !== want.pixel_x)
					report_mismatch($sformatf("point %0d pixel_x got %h expected %h",
						points_checked, got.pixel_x, want.pixel_x));
				if (got.pixel_y !== want.pixel_y)
					report_mismatch($sformatf("point %0d pixel_y got %h expected %h",
						points_checked, got.pixel_y, want.pixel_y));
				if (got.last_of_group !== want.last_of_group)
					report_mismatch($sformatf("point %0d last_of_group got %b expected %b",
						points_checked, got.last_of_group, want.last_of_group));
				if (got.circle_done !== want.circle_done)
					report_mismatch($sformatf("point %0d circle_done got %b expected %b",
						points_checked, got.circle_done, want.circle_done));
			end
			points_checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	mcr_pkg::req_t req = '0;
	logic full;
	logic empty;
	mcr_pkg::res_t res;

	bit steady_push = 1'b0;
	bit steady_pop = 1'b0;
	int cycles = 0;
	int items_sent = 0;

	circle_scoreboard sb = new();

	midpoint_circle_rasterizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.req    (req),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Observe both handshakes with the values held before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_request(req);
			if (pop && !empty)
				sb.check_result(res);
		end
	end

	// Idle length: none in steady mode, else mostly none or short, now and then long.
	function automatic int pick_gap(input bit steady);
		int roll;
		roll = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic mcr_pkg::req_t make_req(input mcr_pkg::req_kind_t kind,
			input logic [9:0] cx, input logic [9:0] cy, input logic [9:0] r);
		mcr_pkg::req_t item;
		item.req_type = kind;
		item.center_x = cx;
		item.center_y = cy;
		item.radius = r;
		return item;
	endfunction

	// A request with every field random.
	function automatic mcr_pkg::req_t rand_req();
		return make_req(mcr_pkg::req_kind_t'($urandom_range(0, 1)),
			10'($urandom), 10'($urandom), 10'($urandom));
	endfunction

	// Offer one request until it is taken, then idle for a random gap, which may be none.
	task automatic send_item(input mcr_pkg::req_t r);
		int gap;
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		items_sent++;
		gap = pick_gap(steady_push);
		if ($urandom_range(0, 31) == 0)
			steady_push = !steady_push;
		if (gap > 0) begin
			push <= 1'b0;
			req <= rand_req();
			repeat (gap) @(posedge clk);
		end
	endtask

	// A step request with don't-care fields.
	task automatic send_step();
		send_item(make_req(mcr_pkg::REQ_STEP, 10'($urandom), 10'($urandom),
			10'($urandom)));
	endtask

	// Result side: pop with random stalls.
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			gap = pick_gap(steady_pop);
			if ($urandom_range(0, 31) == 0)
				steady_pop = !steady_pop;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int r;
		int steps;
		int roll;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a step straight after reset yields nothing.
		send_step();
		// Zero radius at the origin: eight copies of the center, done at once.
		send_item(make_req(mcr_pkg::REQ_START, 10'd0, 10'd0, 10'd0));
		send_step();
		// Largest center and radius, a few steps, then abandoned by a new start.
		send_item(make_req(mcr_pkg::REQ_START, 10'd1023, 10'd1023, 10'd1023));
		repeat (3) send_step();
		send_item(make_req(mcr_pkg::REQ_START, 10'd0, 10'd1023, 10'd1));
		repeat (2) send_step();
		// Largest radius at a corner, so that points fall below zero.
		send_item(make_req(mcr_pkg::REQ_START, 10'd1023, 10'd0, 10'd1023));
		repeat (2) send_step();
		// Alternating bit patterns in every field.
		send_item(make_req(mcr_pkg::REQ_START, 10'd682, 10'd341, 10'd682));
		send_step();
		send_item(make_req(mcr_pkg::REQ_START, 10'd341, 10'd682, 10'd341));
		send_step();
		// Small circle run to the end, with a step past the final group.
		send_item(make_req(mcr_pkg::REQ_START, 10'd5, 10'd5, 10'd2));
		repeat (3) send_step();
		send_item(make_req(mcr_pkg::REQ_START, 10'd1023, 10'd1023, 10'd0));
		send_step();

		// Random part: mostly whole circles, some noise and cut-short circles.
		while (items_sent < TARGET_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				n = $urandom_range(0, 99);
				if (n < 10)
					r = 0;
				else if (n < 80)
					r = $urandom_range(1, 30);
				else
					r = $urandom_range(0, 1023);
				if (r <= 64)
					steps = (r * 181) / 256 + 2;
				else
					steps = $urandom_range(4, 40);
				if ($urandom_range(0, 99) < 15)
					steps = $urandom_range(0, steps);
				send_item(make_req(mcr_pkg::REQ_START, 10'($urandom), 10'($urandom),
					10'(r)));
				repeat (steps) send_step();
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_item(rand_req());
			end
		end
		push <= 1'b0;
		// Let the last request transfer reach the scoreboard.
		@(posedge clk);

		// Drain everything still expected, then watch for stray points.
		while (sb.expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_points.size() != 0)
			sb.report_mismatch($sformatf("%0d expected points never arrived",
				sb.expected_points.size()));

		$display("covered %0d requests, %0d circle starts, %0d point groups",
			items_sent, sb.starts_seen, sb.groups_predicted);
		$display("%0d points checked in %0d cycles, mismatches: %0d",
			sb.points_checked, cycles, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/mcr_pkg.sv
src/mcr_front.sv
src/mcr_group_fifo.sv
src/mcr_back.sv
src/midpoint_circle_rasterizer_top.sv
verif/midpoint_circle_rasterizer_top_tb.sv
